// ===== hdl/rgi_pkg.sv =====
// ----------------------------------------------------------------------------
// rgi_pkg
// Item layouts, field positions and register codes of the ring gateway
// initiator.
// ----------------------------------------------------------------------------
package rgi_pkg;

   localparam int CMD_W       = 37;
   localparam int RSP_W       = 33;
   localparam int CMD_EOP_BIT = 36;
   localparam int RSP_EOP_BIT = 32;
   localparam int SRC_ID_LSB  = 20;
   localparam int SRC_ID_W    = 8;
   localparam int MAP_WORD_W  = 64;
   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_DATA_W  = 64;
   localparam int REQ_TDATA_W = 120;
   localparam int RSP_TDATA_W = 112;

   localparam logic START_WITH_TOKEN = 1'b0;

   // register codes, taken from paddr[5:3]
   localparam logic [2:0] REG_LOCAL_SIDE = 3'd0;
   localparam logic [2:0] REG_LOCALITY0  = 3'd1;
   localparam logic [2:0] REG_LOCALITY1  = 3'd2;
   localparam logic [2:0] REG_LOCALITY2  = 3'd3;
   localparam logic [2:0] REG_LOCALITY3  = 3'd4;

   typedef struct packed {
      logic [4:0]       pad;
      logic             gate_rsp_wok;
      logic [RSP_W-1:0] ring_rsp_data;
      logic             ring_rsp_wok;
      logic             ring_rsp_rok;
      logic             ring_rsp_grant_in;
      logic [CMD_W-1:0] gate_cmd_data;
      logic             gate_cmd_rok;
      logic [CMD_W-1:0] ring_cmd_data;
      logic             ring_cmd_rok;
      logic             ring_cmd_wok;
      logic             ring_cmd_grant_in;
   } req_item_type;

   typedef struct packed {
      logic             pad;
      logic [RSP_W-1:0] gate_rsp_data;
      logic             gate_rsp_w;
      logic             ring_rsp_r;
      logic [RSP_W-1:0] ring_rsp_out_data;
      logic             ring_rsp_w;
      logic             ring_rsp_grant_out;
      logic             gate_cmd_r;
      logic             ring_cmd_r;
      logic [CMD_W-1:0] ring_cmd_out_data;
      logic             ring_cmd_w;
      logic             ring_cmd_grant_out;
   } rsp_item_type;

endpackage

// ===== hdl/rgi_ram.sv =====
// ----------------------------------------------------------------------------
// rgi_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rgi_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ring_gateway_initiator_top.sv =====
// ----------------------------------------------------------------------------
// ring_gateway_initiator_top
// Gateway initiator between a command/response ring and a local gateway.
// ----------------------------------------------------------------------------
// One item on req is one ring clock cycle of handshake signals; for each item
// exactly one result item appears on rsp, in order. An item is taken every
// clock cycle while rsp_tready is high: the token machine, the response
// router and the response fifo are all updated in one pass at the edge that
// accepts the item, and the result sits in a single output register, so it
// shows on rsp in the cycle after the item is accepted. The response fifo
// lives in a RAM of RSPQ_DEPTH entries whose head is prefetched, so no
// clearing pass is needed after reset. The locality map and local flag are
// written over the csr port at byte addresses 0, 8, 16, 24 and 32.
module ring_gateway_initiator_top #(
   parameter int RSPQ_DEPTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // ring_cmd_grant_in, ring_cmd_wok, ring_cmd_rok, ring_cmd_data[36:0],
   // gate_cmd_rok, gate_cmd_data[36:0], ring_rsp_grant_in, ring_rsp_rok,
   // ring_rsp_wok, ring_rsp_data[32:0], gate_rsp_wok, zero pad
   input  logic [rgi_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // ring_cmd_grant_out, ring_cmd_w, ring_cmd_out_data[36:0], ring_cmd_r,
   // gate_cmd_r, ring_rsp_grant_out, ring_rsp_w, ring_rsp_out_data[32:0],
   // ring_rsp_r, gate_rsp_w, gate_rsp_data[32:0], zero pad
   output logic [rgi_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rgi_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rgi_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rgi_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int AW = (RSPQ_DEPTH > 1) ? $clog2(RSPQ_DEPTH) : 1;
   localparam int CW = $clog2(RSPQ_DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(RSPQ_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(RSPQ_DEPTH);

   localparam logic [1:0] CMD_PASS  = 2'd0;
   localparam logic [1:0] CMD_HOLD  = 2'd1;
   localparam logic [1:0] CMD_SEND  = 2'd2;
   localparam logic [1:0] RSP_SCAN  = 2'd0;
   localparam logic [1:0] RSP_LOCAL = 2'd1;
   localparam logic [1:0] RSP_RING  = 2'd2;

   localparam logic [1:0] CMD_RESET = rgi_pkg::START_WITH_TOKEN ? CMD_HOLD : CMD_PASS;

   // configuration
   logic                              local_side_ff;
   logic [rgi_pkg::MAP_WORD_W-1:0]    locality0_ff;
   logic [rgi_pkg::MAP_WORD_W-1:0]    locality1_ff;
   logic [rgi_pkg::MAP_WORD_W-1:0]    locality2_ff;
   logic [rgi_pkg::MAP_WORD_W-1:0]    locality3_ff;
   logic [4*rgi_pkg::MAP_WORD_W-1:0]  locality_map;
   logic                              csr_write;
   logic [2:0]                        csr_index;

   // state
   logic [1:0]                        cmd_state_ff, cmd_state_in;
   logic [1:0]                        rsp_state_ff, rsp_state_in;
   logic [AW-1:0]                     head_ff, head_in;
   logic [AW-1:0]                     tail_ff, tail_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic                              bypass_ff, bypass_in;
   logic [rgi_pkg::RSP_W-1:0]         bypass_data_ff;
   logic [rgi_pkg::RSP_W-1:0]         ram_q;
   logic [rgi_pkg::RSP_W-1:0]         head_data;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   rgi_pkg::rsp_item_type             rsp_item_ff, rsp_item_in;

   rgi_pkg::req_item_type             req;
   logic                              accept;
   logic                              send;
   logic                              g_eop;
   logic                              r_eop;
   logic                              fifo_wok;
   logic                              fifo_rok;
   logic                              loc;
   logic [rgi_pkg::SRC_ID_W-1:0]      src_id;
   logic                              push_raw;
   logic                              push;
   logic                              pop;
   logic [AW-1:0]                     head_inc;
   logic [AW-1:0]                     tail_inc;

   assign req          = req_tdata;
   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign accept       = req_tvalid && req_tready;
   assign locality_map = {locality3_ff, locality2_ff, locality1_ff, locality0_ff};

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[5:3];

   always_comb begin
      unique case (csr_index)
         rgi_pkg::REG_LOCAL_SIDE: csr_prdata = {63'd0, local_side_ff};
         rgi_pkg::REG_LOCALITY0:  csr_prdata = locality0_ff;
         rgi_pkg::REG_LOCALITY1:  csr_prdata = locality1_ff;
         rgi_pkg::REG_LOCALITY2:  csr_prdata = locality2_ff;
         rgi_pkg::REG_LOCALITY3:  csr_prdata = locality3_ff;
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_side_ff <= 1'b0;
         locality0_ff  <= '0;
         locality1_ff  <= '0;
         locality2_ff  <= '0;
         locality3_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            rgi_pkg::REG_LOCAL_SIDE: local_side_ff <= csr_pwdata[0];
            rgi_pkg::REG_LOCALITY0:  locality0_ff  <= csr_pwdata;
            rgi_pkg::REG_LOCALITY1:  locality1_ff  <= csr_pwdata;
            rgi_pkg::REG_LOCALITY2:  locality2_ff  <= csr_pwdata;
            rgi_pkg::REG_LOCALITY3:  locality3_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // per cycle decode
   assign send     = req.gate_cmd_rok && req.ring_cmd_wok;
   assign g_eop    = req.gate_cmd_data[rgi_pkg::CMD_EOP_BIT];
   assign r_eop    = req.ring_rsp_data[rgi_pkg::RSP_EOP_BIT];
   assign fifo_wok = count_ff < FULL_CNT;
   assign fifo_rok = count_ff != '0;
   assign src_id   = req.ring_rsp_data[rgi_pkg::SRC_ID_LSB +: rgi_pkg::SRC_ID_W];
   assign loc      = locality_map[src_id] == local_side_ff;
   assign head_inc = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
   assign tail_inc = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
   assign head_data = bypass_ff ? bypass_data_ff : ram_q;

   always_comb begin
      rsp_item_in = '0;

      // command side
      unique case (cmd_state_ff)
         CMD_HOLD: begin
            rsp_item_in.ring_cmd_grant_out = !send;
            rsp_item_in.gate_cmd_r         = send;
         end
         CMD_SEND: begin
            rsp_item_in.ring_cmd_grant_out = send && g_eop;
            rsp_item_in.gate_cmd_r         = send;
         end
         default: begin
            rsp_item_in.ring_cmd_grant_out = req.ring_cmd_grant_in && !req.gate_cmd_rok;
            rsp_item_in.gate_cmd_r         = 1'b0;
         end
      endcase
      if (cmd_state_ff == CMD_HOLD || cmd_state_ff == CMD_SEND) begin
         rsp_item_in.ring_cmd_w        = req.gate_cmd_rok;
         rsp_item_in.ring_cmd_out_data = req.gate_cmd_data;
      end else begin
         rsp_item_in.ring_cmd_w        = req.ring_cmd_rok;
         rsp_item_in.ring_cmd_out_data = req.ring_cmd_data;
      end
      rsp_item_in.ring_cmd_r = req.ring_cmd_wok;

      // response side
      unique case (rsp_state_ff)
         RSP_RING:  rsp_item_in.ring_rsp_r = req.ring_rsp_wok;
         RSP_LOCAL: rsp_item_in.ring_rsp_r = fifo_wok;
         default:   rsp_item_in.ring_rsp_r = req.ring_rsp_rok &&
                       ((loc && fifo_wok) || (!loc && req.ring_rsp_wok));
      endcase
      rsp_item_in.ring_rsp_grant_out = req.ring_rsp_grant_in;
      rsp_item_in.ring_rsp_w         = req.ring_rsp_rok;
      rsp_item_in.ring_rsp_out_data  = req.ring_rsp_data;
      rsp_item_in.gate_rsp_w         = fifo_rok;
      rsp_item_in.gate_rsp_data      = fifo_rok ? head_data : '0;
   end

   // next state
   always_comb begin
      cmd_state_in = cmd_state_ff;
      rsp_state_in = rsp_state_ff;
      push_raw     = 1'b0;

      unique case (cmd_state_ff)
         CMD_HOLD: begin
            if (send) begin
               cmd_state_in = CMD_SEND;
            end else if (!req.ring_cmd_grant_in) begin
               cmd_state_in = CMD_PASS;
            end
         end
         CMD_SEND: begin
            if (send && g_eop) begin
               cmd_state_in = req.ring_cmd_grant_in ? CMD_HOLD : CMD_PASS;
            end
         end
         default: begin
            cmd_state_in = (req.ring_cmd_grant_in && req.gate_cmd_rok) ? CMD_HOLD : CMD_PASS;
         end
      endcase

      unique case (rsp_state_ff)
         RSP_LOCAL: begin
            if (req.ring_rsp_rok && fifo_wok) begin
               push_raw = 1'b1;
               if (r_eop) begin
                  rsp_state_in = RSP_SCAN;
               end
            end
         end
         RSP_RING: begin
            if (req.ring_rsp_rok && req.ring_rsp_wok && r_eop) begin
               rsp_state_in = RSP_SCAN;
            end
         end
         default: begin
            rsp_state_in = RSP_SCAN;
            if (req.ring_rsp_rok) begin
               if (loc && fifo_wok) begin
                  rsp_state_in = RSP_LOCAL;
                  push_raw     = 1'b1;
               end else if (!loc && req.ring_rsp_wok) begin
                  rsp_state_in = RSP_RING;
               end
            end
         end
      endcase
   end

   // response fifo pointers
   assign push      = accept && push_raw;
   assign pop       = accept && req.gate_rsp_wok && fifo_rok;
   assign head_in   = pop ? head_inc : head_ff;
   assign tail_in   = push ? tail_inc : tail_ff;
   assign bypass_in = push && (tail_ff == head_in);

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_state_ff <= CMD_RESET;
         rsp_state_ff <= RSP_SCAN;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         bypass_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            cmd_state_ff <= cmd_state_in;
            rsp_state_ff <= rsp_state_in;
            head_ff      <= head_in;
            tail_ff      <= tail_in;
            count_ff     <= count_in;
         end
         bypass_ff    <= bypass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_item_ff <= rsp_item_in;
      end
      if (push) begin
         bypass_data_ff <= req.ring_rsp_data;
      end
   end

   rgi_ram #(
      .WIDTH(rgi_pkg::RSP_W),
      .DEPTH(RSPQ_DEPTH)
   ) u_rsp_fifo_ram (
      .clock  (clock),
      .wr_en  (push),
      .wr_addr(tail_ff),
      .wr_data(req.ring_rsp_data),
      .rd_addr(head_in),
      .rd_data(ram_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff;

   // checks
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("response fifo count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_CNT) |-> head_ff == tail_ff)
      else $error("fifo pointers disagree with count");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted item produced no result");

   assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(cmd_state_ff) && $stable(rsp_state_ff) && $stable(count_ff))
      else $error("state moved without an item");

endmodule
